// ===== sv/soc_pkg.sv =====
// package for the subsequence occurrence counter: codes, types and defaults
`timescale 1ns / 1ps
`default_nettype none
package soc_pkg;

    localparam int DEF_MAX_PATTERN   = 16;
    localparam int DEF_ELEMENT_WIDTH = 32;
    localparam int DEF_COUNT_WIDTH   = 32;

    localparam int FUNC_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 32;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== sv/soc_ctrl.sv =====
// controller: word handshake, sequencing and result valid
`timescale 1ns / 1ps
`default_nettype none
module soc_ctrl
    import soc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
                cmd.load = s_tvalid && s_tready;
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== sv/soc_datapath.sv =====
// datapath: pattern store, row of prefix count cells and result register
`timescale 1ns / 1ps
`default_nettype none
module soc_datapath
    import soc_pkg::*;
#(
    parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctrl_cmd_t              cmd,
    input  wire func_t                  func,
    input  wire logic [VALUE_W-1:0]     value,
    output logic [COUNT_OUT_W-1:0]      count,
    output logic                        saturated,
    output logic                        rejected
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    func_t                    func_reg;
    logic [ELEMENT_WIDTH-1:0] elem_reg;

    logic [ELEMENT_WIDTH-1:0] store_reg  [MAX_PATTERN];
    logic [ELEMENT_WIDTH-1:0] store_next [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0]   cnt_reg    [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0]   cnt_next   [MAX_PATTERN];
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic                     sat_reg;
    logic                     sat_next;
    logic                     rej_next;
    logic [COUNT_WIDTH-1:0]   below      [MAX_PATTERN];
    logic [COUNT_WIDTH:0]     sum        [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]   hit;
    logic [MAX_PATTERN-1:0]   cell_sat;
    logic [LEN_W-1:0]         last_len;
    logic [COUNT_WIDTH-1:0]   full_cnt;

    logic [COUNT_OUT_W-1:0]   count_reg;
    logic                     saturated_reg;
    logic                     rejected_reg;

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            elem_reg <= ELEMENT_WIDTH'($unsigned(value));
        end
    end

    // cell row update, all cells read the old counts
    always_comb
    begin
        len_next = len_reg;
        sat_next = sat_reg;
        rej_next = 1'b0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            store_next[j] = store_reg[j];
            cnt_next[j]   = cnt_reg[j];
            below[j]      = (j == 0) ? COUNT_WIDTH'(1) : cnt_reg[(j == 0) ? 0 : j - 1];
            sum[j]        = {1'b0, cnt_reg[j]} + {1'b0, below[j]};
            hit[j]        = (LEN_W'(j) < len_reg) && (store_reg[j] == elem_reg);
            cell_sat[j]   = sum[j][COUNT_WIDTH] || (sum[j][COUNT_WIDTH-1:0] == COUNT_MAX);
        end

        case (func_reg)
            FUNC_START:
            begin
                len_next = '0;
                sat_next = 1'b0;
                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    cnt_next[j] = '0;
                end
            end
            FUNC_APPEND:
            begin
                if (len_reg < LEN_W'(MAX_PATTERN))
                begin
                    for (int j = 0; j < MAX_PATTERN; j++)
                    begin
                        if (len_reg == LEN_W'(j))
                        begin
                            store_next[j] = elem_reg;
                            cnt_next[j]   = '0;
                        end
                    end
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    rej_next = 1'b1;
                end
            end
            FUNC_TEXT:
            begin
                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    if (hit[j])
                    begin
                        cnt_next[j] = cell_sat[j] ? COUNT_MAX : sum[j][COUNT_WIDTH-1:0];
                    end
                end
                sat_next = sat_reg || |(hit & cell_sat);
            end
            default:
            begin
                rej_next = 1'b0;
            end
        endcase

        last_len = len_next - LEN_W'(1);
        full_cnt = (len_next == '0) ? COUNT_WIDTH'(1) : cnt_next[last_len[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                store_reg[j] <= store_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            sat_reg <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                cnt_reg[j] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            len_reg <= len_next;
            sat_reg <= sat_next;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                cnt_reg[j] <= cnt_next[j];
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            count_reg     <= COUNT_OUT_W'(full_cnt);
            saturated_reg <= sat_next;
            rejected_reg  <= rej_next;
        end
    end

    assign count     = count_reg;
    assign saturated = saturated_reg;
    assign rejected  = rejected_reg;

endmodule
`default_nettype wire

// ===== sv/subsequence_occurrence_counter.sv =====
// top level of the subsequence occurrence counter
`timescale 1ns / 1ps
`default_nettype none
// Counts the ways a loaded pattern occurs as an ordered, not necessarily
// contiguous, subsequence of a text stream. Each input word is a command in
// s_tuser (start, append pattern element, text element, read) with its element
// in s_tdata, and every word returns one result word with the full-pattern
// count, a sticky saturation flag and a flag for an append that found the
// pattern store full. A word is first captured, then in the execute state the
// whole row of prefix count cells updates together and the result register
// loads. No new word is taken until the last one has been through the cell
// row, and a pending result that is not taken holds off the next word.
module subsequence_occurrence_counter
    import soc_pkg::*;
#(
    parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,  // value
    input  wire logic [FUNC_W-1:0]     s_tuser,  // func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata   // count, saturated, rejected, zero pad
);

    ctrl_cmd_t              cmd;
    logic [COUNT_OUT_W-1:0] count;
    logic                   saturated;
    logic                   rejected;

    soc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    soc_datapath #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .func      (func_t'(s_tuser)),
        .value     (s_tdata),
        .count     (count),
        .saturated (saturated),
        .rejected  (rejected)
    );

    assign m_tdata = {6'd0, rejected, saturated, count};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word taken while the previous one is in the cell row");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("no result word after an accepted word");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_START) |=> ##1
        (m_tdata[31:0] == 32'd1 && !m_tdata[32] && !m_tdata[33]))
        else $error("start did not clear the counts");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the subsequence occurrence counter: directed and random streams checked word by word
`timescale 1ns / 1ps
module tb;
    import soc_pkg::*;

    localparam int          PAT_DEPTH   = DEF_MAX_PATTERN;
    localparam logic [63:0] COUNT_LIMIT = (64'd1 << DEF_COUNT_WIDTH) - 64'd1;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_WORDS = 850;

    typedef struct {
        logic [COUNT_OUT_W-1:0] count;
        logic                   saturated;
        logic                   rejected;
    } count_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    // predicted pattern state
    logic [VALUE_W-1:0]     pattern_elem [PAT_DEPTH];
    logic [COUNT_OUT_W-1:0] prefix_count [PAT_DEPTH];
    int unsigned            pattern_len;
    logic                   sat_seen;

    count_result_t          pending_counts [$];
    count_result_t          oldest;
    int                     mismatches;
    int                     words_sent;
    int                     cycle_count;
    bit                     tx_idle_on;
    bit                     rx_idle_on;
    int                     rx_hold_cycles;

    subsequence_occurrence_counter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL subsequence_occurrence_counter");
            $finish;
        end
    end

    function automatic count_result_t count_step(func_t f, logic [VALUE_W-1:0] v);
        count_result_t          r;
        logic [63:0]            sum;
        logic [COUNT_OUT_W-1:0] below;
        r.rejected = 1'b0;
        case (f)
            FUNC_START:
            begin
                for (int k = 0; k < PAT_DEPTH; k++)
                    prefix_count[k] = '0;
                pattern_len = 0;
                sat_seen    = 1'b0;
            end
            FUNC_APPEND:
            begin
                if (pattern_len < PAT_DEPTH)
                begin
                    pattern_elem[pattern_len] = v;
                    prefix_count[pattern_len] = '0;
                    pattern_len++;
                end
                else
                    r.rejected = 1'b1;
            end
            FUNC_TEXT:
            begin
                // right to left so each element extends a prefix at most once
                for (int j = pattern_len; j >= 1; j--)
                begin
                    if (pattern_elem[j-1] == v)
                    begin
                        below = (j == 1) ? 1 : prefix_count[j-2];
                        sum   = 64'(prefix_count[j-1]) + 64'(below);
                        if (sum >= COUNT_LIMIT)
                        begin
                            sum      = COUNT_LIMIT;
                            sat_seen = 1'b1;
                        end
                        prefix_count[j-1] = sum[COUNT_OUT_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count     = (pattern_len == 0) ? 1 : prefix_count[pattern_len-1];
        r.saturated = sat_seen;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_counts.size() == 0)
                note_mismatch("unexpected word", 0, m_tdata);
            else
            begin
                oldest = pending_counts.pop_front();
                if (m_tdata[31:0] !== oldest.count)
                    note_mismatch("count", oldest.count, m_tdata[31:0]);
                if (m_tdata[32] !== oldest.saturated)
                    note_mismatch("saturated", oldest.saturated, m_tdata[32]);
                if (m_tdata[33] !== oldest.rejected)
                    note_mismatch("rejected", oldest.rejected, m_tdata[33]);
                if (m_tdata[M_TDATA_W-1:34] !== '0)
                    note_mismatch("padding", 0, m_tdata[M_TDATA_W-1:34]);
            end
        end
    end

    // result side: random stalls, plus a long hold when asked
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_word(func_t f, logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        pending_counts.push_back(count_step(f, v));
        words_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_word(FUNC_READ, $urandom);
        send_word(FUNC_TEXT, $urandom);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        send_word(FUNC_START, 32'hFFFF_FFFF);
        send_word(FUNC_APPEND, 32'h0000_0000);
        send_word(FUNC_APPEND, 32'hFFFF_FFFF);
        send_word(FUNC_TEXT, 32'h0000_0000);
        send_word(FUNC_TEXT, 32'h7FFF_FFFF);
        send_word(FUNC_TEXT, 32'hFFFF_FFFF);
        send_word(FUNC_TEXT, 32'h8000_0000);
        send_word(FUNC_READ, 32'h0000_0000);
        send_word(FUNC_START, 32'h0000_0000);
        send_word(FUNC_APPEND, 32'h8000_0000);
        send_word(FUNC_APPEND, 32'h7FFF_FFFF);
        send_word(FUNC_TEXT, 32'h8000_0000);
        send_word(FUNC_TEXT, 32'h7FFF_FFFF);
        send_word(FUNC_READ, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_store_full();
        send_word(FUNC_START, 0);
        for (int k = 0; k < PAT_DEPTH; k++)
            send_word(FUNC_APPEND, 32'h100 + k);
        send_word(FUNC_APPEND, 32'h100);
        for (int k = 0; k < PAT_DEPTH; k++)
            send_word(FUNC_TEXT, 32'h100 + k);
        send_word(FUNC_READ, 0);
        wait_for_results();
    endtask

    task automatic test_append_after_text();
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        a = $urandom;
        b = ~a;
        send_word(FUNC_START, 0);
        send_word(FUNC_APPEND, a);
        send_word(FUNC_TEXT, a);
        send_word(FUNC_TEXT, a);
        send_word(FUNC_APPEND, b);
        send_word(FUNC_TEXT, b);
        send_word(FUNC_TEXT, a);
        send_word(FUNC_READ, 0);
        wait_for_results();
    endtask

    task automatic test_saturation();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        send_word(FUNC_START, 0);
        for (int k = 0; k < PAT_DEPTH; k++)
            send_word(FUNC_APPEND, v);
        // binomial growth passes the count ceiling well within forty words
        for (int k = 0; k < 40; k++)
            send_word(FUNC_TEXT, v);
        send_word(FUNC_READ, 0);
        send_word(FUNC_START, 0);
        send_word(FUNC_READ, 0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
        send_word(FUNC_START, 0);
        send_word(FUNC_APPEND, 32'h5A5A_5A5A);
        send_word(FUNC_APPEND, 32'hA5A5_A5A5);
        for (int k = 0; k < 30; k++)
            send_word(FUNC_TEXT, k[0] ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A);
        send_word(FUNC_READ, 0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [VALUE_W-1:0] alphabet [4];
        int                 n_sym;
        int                 plen;
        int                 tlen;
        int                 pick;
        while (words_sent < RANDOM_WORDS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
            begin
                n_sym = $urandom_range(1, 4);
                for (int k = 0; k < 4; k++)
                    alphabet[k] = $urandom;
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                send_word(FUNC_START, $urandom);
                for (int k = 0; k < plen; k++)
                    send_word(FUNC_APPEND, alphabet[$urandom_range(0, n_sym - 1)]);
                if (plen == PAT_DEPTH && $urandom_range(0, 1) == 1)
                    send_word(FUNC_APPEND, $urandom);
                tlen = $urandom_range(4, 30);
                for (int k = 0; k < tlen; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        send_word(FUNC_READ, $urandom);
                    else if (pick == 1)
                        send_word(FUNC_APPEND, alphabet[$urandom_range(0, n_sym - 1)]);
                    else if (pick == 2)
                        send_word(FUNC_TEXT, $urandom);
                    else
                        send_word(FUNC_TEXT, alphabet[$urandom_range(0, n_sym - 1)]);
                end
                send_word(FUNC_READ, $urandom);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_word(func_t'($urandom_range(0, 3)), $urandom);
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_READ;
        mismatches     = 0;
        words_sent     = 0;
        cycle_count    = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        pattern_len    = 0;
        sat_seen       = 1'b0;
        for (int k = 0; k < PAT_DEPTH; k++)
        begin
            pattern_elem[k] = '0;
            prefix_count[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_store_full();
        test_append_after_text();
        test_saturation();
        test_backpressure();
        test_random_traffic();

        repeat (20) @(posedge clk);
        mismatches += pending_counts.size();
        if (mismatches == 0)
            $display("PASS subsequence_occurrence_counter");
        else
            $display("FAIL subsequence_occurrence_counter");
        $finish;
    end

endmodule
